/* hdl/flcp_pkg.sv */
// Shared types, codes and sine table helpers for the free-look camera pose block.
package flcp_pkg;

   typedef enum logic [2:0] {
      CMD_QUERY     = 3'd0,
      CMD_ROTATE    = 3'd1,
      CMD_MOVE      = 3'd2,
      CMD_SET_POSE  = 3'd3,
      CMD_SET_POS   = 3'd4,
      CMD_SET_YAW   = 3'd5,
      CMD_SET_PITCH = 3'd6
   } flcp_cmd_type;

   // Register index, taken from bit 2 of the byte address.
   localparam logic REG_PITCH_MIN = 1'b0;
   localparam logic REG_PITCH_MAX = 1'b1;

   localparam logic signed [15:0] PITCH_MIN_RESET = -16'sd16200;
   localparam logic signed [15:0] PITCH_MAX_RESET = 16'sd16200;

   // Half pi in Q2.30, used to build the quarter-wave table.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [2:0]          cmd;
      logic signed [31:0]  pos_x;
      logic signed [31:0]  pos_y;
      logic signed [31:0]  pos_z;
      logic signed [15:0]  yaw_angle;
      logic signed [15:0]  pitch_angle;
      logic signed [31:0]  forward_step;
      logic signed [31:0]  right_step;
      logic signed [31:0]  vertical_step;
   } flcp_req_type;

   typedef struct packed {
      logic signed [31:0]  cam_x;
      logic signed [31:0]  cam_y;
      logic signed [31:0]  cam_z;
      logic signed [15:0]  cam_yaw;
      logic signed [15:0]  cam_pitch;
      logic signed [15:0]  dir_x;
      logic signed [15:0]  dir_y;
      logic signed [15:0]  dir_z;
      logic signed [31:0]  aim_x;
      logic signed [31:0]  aim_y;
      logic signed [31:0]  aim_z;
   } flcp_rsp_type;

   // Divides a Taylor term by (2k)(2k+1); only evaluated at elaboration.
   function automatic logic [63:0] series_div(input logic [63:0] t, input int k);
      logic [63:0] q;
      case (k)
         1: begin
            q = t / 64'd6;
         end
         2: begin
            q = t / 64'd20;
         end
         3: begin
            q = t / 64'd42;
         end
         4: begin
            q = t / 64'd72;
         end
         5: begin
            q = t / 64'd110;
         end
         6: begin
            q = t / 64'd156;
         end
         7: begin
            q = t / 64'd210;
         end
         8: begin
            q = t / 64'd272;
         end
         9: begin
            q = t / 64'd342;
         end
         10: begin
            q = t / 64'd420;
         end
         11: begin
            q = t / 64'd506;
         end
         default: begin
            q = t / 64'd600;
         end
      endcase
      return q;
   endfunction

   // Sine of an angle given in Q2.30 radians, returned as a Q1.14 magnitude.
   function automatic logic [14:0] sine_series(input logic [63:0] x);
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        rounded;
      term = x;
      sum  = signed'(x);
      for (int k = 1; k <= 12; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = series_div(term, k);
         if ((k & 1) != 0) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      rounded = (unsigned'(sum) * 64'd16384 + (64'd1 << 29)) >> 30;
      return rounded[14:0];
   endfunction

endpackage

/* hdl/free_look_camera_pose_top.sv */
// Free-look camera pose block: pose state, sine lookup, move and aim pipeline.
//
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid/req_ready    req_data  (flcp_req_type)
//  rsp       out        rsp_valid/rsp_ready    rsp_data  (flcp_rsp_type)
//  csr       in/out     psel/penable/pwrite    paddr, pwdata, prdata (pitch limits)
//
// The block takes one request every cycle while the result side does not stall,
// and each result passes through the stages below to the result register. The
// depth is set by the registered sine table read and the products that follow it.
// Reset is synchronous and active high; it clears the pose to zero and loads the
// pitch limits with their defaults. A stall on the result side holds each stage that
// cannot move on, while empty stages ahead of it keep filling.
//
// Pipeline, one stage per register:
//   accept : yaw and pitch are updated and clamped; they live in heading_ff/tilt_ff.
//   stage 1: table index from the new yaw and pitch; the table read is registered.
//   stage 2: signed sine and cosine, then the move and direction products.
//   stage 3: move deltas and direction vector are rounded to their final width.
//   stage 4: the position is updated; where_x_ff..where_z_ff hold the running pose.
//   output : aim point = position + 4 * direction, saturated, in the result register.
// Yaw and pitch change only at the accept step and the position only at stage 4,
// so every request sees the state left by the requests before it.
module free_look_camera_pose_top
   import flcp_pkg::*;
#(
   parameter int SINE_TABLE_ENTRIES = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  flcp_req_type  req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output flcp_rsp_type  rsp_data,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int PROD_W = IDX_W + 15;
   localparam logic [PROD_W-1:0] N_MULT = PROD_W'(SINE_TABLE_ENTRIES);
   localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
   localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

   // Quarter-wave sine table, one copy per angle so each sees two reads a cycle.
   logic [14:0] sine_rom_yaw   [0:SINE_TABLE_ENTRIES];
   logic [14:0] sine_rom_pitch [0:SINE_TABLE_ENTRIES];

   for (genvar g = 0; g <= SINE_TABLE_ENTRIES; g++) begin : g_rom
      localparam logic [63:0] ArgQ30 = (HALF_PI_Q30 * 64'(g)) / 64'(SINE_TABLE_ENTRIES);
      assign sine_rom_yaw[g]   = sine_series(ArgQ30);
      assign sine_rom_pitch[g] = sine_series(ArgQ30);
   end

   // Table index of an angle: the remainder within the quadrant, mirrored in the
   // odd quadrants, scaled to the table length.
   function automatic logic [IDX_W-1:0] rom_index(input logic [15:0] angle);
      logic [14:0]       span;
      logic [PROD_W-1:0] prod;
      span = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
      prod = PROD_W'(span) * N_MULT;
      return prod[14 +: IDX_W];
   endfunction

   function automatic logic signed [15:0] apply_sign(input logic [14:0] mag,
                                                     input logic neg);
      logic signed [15:0] v;
      v = signed'({1'b0, mag});
      return neg ? -v : v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic               cfg_wr;
   logic signed [15:0] pitch_min_ff;
   logic signed [15:0] pitch_max_ff;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == REG_PITCH_MAX) ? {16'd0, pitch_max_ff}
                                               : {16'd0, pitch_min_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_min_ff <= PITCH_MIN_RESET;
         pitch_max_ff <= PITCH_MAX_RESET;
      end else if (cfg_wr) begin
         if (paddr[2] == REG_PITCH_MAX) begin
            pitch_max_ff <= pwdata[15:0];
         end else begin
            pitch_min_ff <= pwdata[15:0];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage handshake: a stage moves on when the next one is empty or moving.
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic mv1, mv2, mv3, mv4, mv5;
   logic free1, free2, free3, free4, free5, rsp_free;
   logic req_fire;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign free5    = !v5_ff || rsp_free;
   assign free4    = !v4_ff || free5;
   assign free3    = !v3_ff || free4;
   assign free2    = !v2_ff || free3;
   assign free1    = !v1_ff || free2;
   assign mv5      = v5_ff && rsp_free;
   assign mv4      = v4_ff && free5;
   assign mv3      = v3_ff && free4;
   assign mv2      = v2_ff && free3;
   assign mv1      = v1_ff && free2;
   assign req_ready = free1;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= req_fire || (v1_ff && !mv1);
         v2_ff        <= mv1 || (v2_ff && !mv2);
         v3_ff        <= mv2 || (v3_ff && !mv3);
         v4_ff        <= mv3 || (v4_ff && !mv4);
         v5_ff        <= mv4 || (v5_ff && !mv5);
         rsp_valid_ff <= mv5 || (rsp_valid_ff && !rsp_ready);
      end
   end

   // ------------------------------------------------------------------
   // Accept: yaw wraps, pitch is clamped against the limits.
   // ------------------------------------------------------------------
   logic [15:0]        heading_ff;
   logic signed [15:0] tilt_ff;
   logic [15:0]        heading_in;
   logic signed [15:0] tilt_in;
   logic signed [16:0] pitch_raw;
   logic signed [16:0] pitch_lo;
   logic               clamp_en;
   flcp_req_type       s1_req_ff;

   always_comb begin
      heading_in = heading_ff;
      pitch_raw  = 17'(tilt_ff);
      clamp_en   = 1'b0;
      case (flcp_cmd_type'(req_data.cmd))
         CMD_ROTATE: begin
            heading_in = heading_ff + req_data.yaw_angle;
            pitch_raw  = 17'(tilt_ff) + 17'(req_data.pitch_angle);
            clamp_en   = 1'b1;
         end
         CMD_SET_POSE: begin
            heading_in = req_data.yaw_angle;
            pitch_raw  = 17'(req_data.pitch_angle);
            clamp_en   = 1'b1;
         end
         CMD_SET_YAW: begin
            heading_in = req_data.yaw_angle;
         end
         CMD_SET_PITCH: begin
            pitch_raw  = 17'(req_data.pitch_angle);
            clamp_en   = 1'b1;
         end
         default: begin
            heading_in = heading_ff;
         end
      endcase
      // Lower limit first, then upper, so crossed limits give the upper one.
      pitch_lo = (pitch_raw < 17'(pitch_min_ff)) ? 17'(pitch_min_ff) : pitch_raw;
      if (!clamp_en) begin
         tilt_in = tilt_ff;
      end else if (pitch_lo > 17'(pitch_max_ff)) begin
         tilt_in = pitch_max_ff;
      end else begin
         tilt_in = pitch_lo[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= 16'd0;
         tilt_ff    <= 16'sd0;
      end else if (req_fire) begin
         heading_ff <= heading_in;
         tilt_ff    <= tilt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_data;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1 to 2: table reads for sine and cosine of yaw and pitch.
   // Cosine is the sine a quarter turn further on.
   // ------------------------------------------------------------------
   logic [15:0]        yaw_cos_angle, pitch_cos_angle;
   logic [14:0]        sin_yaw_mag_ff, cos_yaw_mag_ff, sin_pitch_mag_ff, cos_pitch_mag_ff;
   logic [3:0]         s2_neg_ff;
   logic [15:0]        s2_heading_ff;
   logic signed [15:0] s2_tilt_ff;
   flcp_req_type       s2_req_ff;

   assign yaw_cos_angle   = heading_ff + 16'h4000;
   assign pitch_cos_angle = tilt_ff + 16'h4000;

   always_ff @(posedge clock) begin
      if (mv1) begin
         sin_yaw_mag_ff   <= sine_rom_yaw[rom_index(heading_ff)];
         cos_yaw_mag_ff   <= sine_rom_yaw[rom_index(yaw_cos_angle)];
         sin_pitch_mag_ff <= sine_rom_pitch[rom_index(tilt_ff)];
         cos_pitch_mag_ff <= sine_rom_pitch[rom_index(pitch_cos_angle)];
         s2_neg_ff        <= {pitch_cos_angle[15], tilt_ff[15],
                              yaw_cos_angle[15], heading_ff[15]};
         s2_heading_ff    <= heading_ff;
         s2_tilt_ff       <= tilt_ff;
         s2_req_ff        <= s1_req_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2 to 3: signed values and products.
   // ------------------------------------------------------------------
   logic signed [15:0] sin_yaw, cos_yaw, sin_pitch, cos_pitch;
   logic signed [47:0] p_cf_ff, p_sr_ff, p_sf_ff, p_cr_ff;
   logic signed [31:0] p_dx_ff, p_dz_ff;
   logic signed [15:0] s3_dir_y_ff;
   logic [15:0]        s3_heading_ff;
   logic signed [15:0] s3_tilt_ff;
   flcp_req_type       s3_req_ff;

   assign sin_yaw   = apply_sign(sin_yaw_mag_ff, s2_neg_ff[0]);
   assign cos_yaw   = apply_sign(cos_yaw_mag_ff, s2_neg_ff[1]);
   assign sin_pitch = apply_sign(sin_pitch_mag_ff, s2_neg_ff[2]);
   assign cos_pitch = apply_sign(cos_pitch_mag_ff, s2_neg_ff[3]);

   always_ff @(posedge clock) begin
      if (mv2) begin
         p_cf_ff       <= cos_yaw * s2_req_ff.forward_step;
         p_sr_ff       <= sin_yaw * s2_req_ff.right_step;
         p_sf_ff       <= sin_yaw * s2_req_ff.forward_step;
         p_cr_ff       <= cos_yaw * s2_req_ff.right_step;
         p_dx_ff       <= cos_pitch * cos_yaw;
         p_dz_ff       <= cos_pitch * sin_yaw;
         s3_dir_y_ff   <= sin_pitch;
         s3_heading_ff <= s2_heading_ff;
         s3_tilt_ff    <= s2_tilt_ff;
         s3_req_ff     <= s2_req_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3 to 4: round half up from Q.14 products.
   // ------------------------------------------------------------------
   logic signed [48:0] move_dx_sum, move_dz_sum;
   logic signed [31:0] dir_x_sum, dir_z_sum;
   logic signed [34:0] move_dx_ff, move_dz_ff;
   logic signed [15:0] s4_dir_x_ff, s4_dir_y_ff, s4_dir_z_ff;
   logic [15:0]        s4_heading_ff;
   logic signed [15:0] s4_tilt_ff;
   flcp_req_type       s4_req_ff;

   assign move_dx_sum = 49'(p_cf_ff) - 49'(p_sr_ff) + 49'sd8192;
   assign move_dz_sum = 49'(p_sf_ff) + 49'(p_cr_ff) + 49'sd8192;
   assign dir_x_sum   = p_dx_ff + 32'sd8192;
   assign dir_z_sum   = p_dz_ff + 32'sd8192;

   always_ff @(posedge clock) begin
      if (mv3) begin
         move_dx_ff    <= move_dx_sum[48:14];
         move_dz_ff    <= move_dz_sum[48:14];
         s4_dir_x_ff   <= dir_x_sum[29:14];
         s4_dir_z_ff   <= dir_z_sum[29:14];
         s4_dir_y_ff   <= s3_dir_y_ff;
         s4_heading_ff <= s3_heading_ff;
         s4_tilt_ff    <= s3_tilt_ff;
         s4_req_ff     <= s3_req_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4 to 5: position update. The stage 5 position registers are the
   // camera position itself.
   // ------------------------------------------------------------------
   logic signed [31:0] where_x_ff, where_y_ff, where_z_ff;
   logic signed [31:0] where_x_in, where_y_in, where_z_in;
   logic signed [15:0] s5_dir_x_ff, s5_dir_y_ff, s5_dir_z_ff;
   logic [15:0]        s5_heading_ff;
   logic signed [15:0] s5_tilt_ff;

   always_comb begin
      where_x_in = where_x_ff;
      where_y_in = where_y_ff;
      where_z_in = where_z_ff;
      case (flcp_cmd_type'(s4_req_ff.cmd))
         CMD_MOVE: begin
            where_x_in = sat32(36'(where_x_ff) + 36'(move_dx_ff));
            where_y_in = sat32(36'(where_y_ff) + 36'(s4_req_ff.vertical_step));
            where_z_in = sat32(36'(where_z_ff) + 36'(move_dz_ff));
         end
         CMD_SET_POSE, CMD_SET_POS: begin
            where_x_in = s4_req_ff.pos_x;
            where_y_in = s4_req_ff.pos_y;
            where_z_in = s4_req_ff.pos_z;
         end
         default: begin
            where_x_in = where_x_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         where_x_ff <= 32'sd0;
         where_y_ff <= 32'sd0;
         where_z_ff <= 32'sd0;
      end else if (mv4) begin
         where_x_ff <= where_x_in;
         where_y_ff <= where_y_in;
         where_z_ff <= where_z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mv4) begin
         s5_dir_x_ff   <= s4_dir_x_ff;
         s5_dir_y_ff   <= s4_dir_y_ff;
         s5_dir_z_ff   <= s4_dir_z_ff;
         s5_heading_ff <= s4_heading_ff;
         s5_tilt_ff    <= s4_tilt_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5 to output: aim point is four times the Q1.14 vector past the
   // position, which puts it one unit ahead in Q16.16.
   // ------------------------------------------------------------------
   flcp_rsp_type rsp_data_ff;
   flcp_rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in.cam_x     = where_x_ff;
      rsp_data_in.cam_y     = where_y_ff;
      rsp_data_in.cam_z     = where_z_ff;
      rsp_data_in.cam_yaw   = s5_heading_ff;
      rsp_data_in.cam_pitch = s5_tilt_ff;
      rsp_data_in.dir_x     = s5_dir_x_ff;
      rsp_data_in.dir_y     = s5_dir_y_ff;
      rsp_data_in.dir_z     = s5_dir_z_ff;
      rsp_data_in.aim_x     = sat32(36'(where_x_ff) +
                                    signed'({{18{s5_dir_x_ff[15]}}, s5_dir_x_ff, 2'b00}));
      rsp_data_in.aim_y     = sat32(36'(where_y_ff) +
                                    signed'({{18{s5_dir_y_ff[15]}}, s5_dir_y_ff, 2'b00}));
      rsp_data_in.aim_z     = sat32(36'(where_z_ff) +
                                    signed'({{18{s5_dir_z_ff[15]}}, s5_dir_z_ff, 2'b00}));
   end

   always_ff @(posedge clock) begin
      if (mv5) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // A clamping command leaves the pitch at or below the upper limit.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !cfg_wr &&
       (req_data.cmd == CMD_ROTATE || req_data.cmd == CMD_SET_POSE ||
        req_data.cmd == CMD_SET_PITCH))
      |=> (tilt_ff <= pitch_max_ff))
      else $error("pitch above upper limit after clamping command");

   // The x and z components of the direction vector never leave the unit range.
   assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> (s5_dir_x_ff <= 16'sd16384 && s5_dir_x_ff >= -16'sd16384 &&
                 s5_dir_z_ff <= 16'sd16384 && s5_dir_z_ff >= -16'sd16384))
      else $error("direction vector out of range");

   // Stage 3, when full and blocked, keeps its request.
   assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !free4) |=> v3_ff)
      else $error("request dropped from a blocked stage");

endmodule
